### sv/olt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ordered list table.
// Used by olt_seq and ordered_list_table_unit; depends on nothing.
package olt_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 8;

    // Request codes
    typedef enum logic [2:0] {
        REQ_GET    = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_DELETE = 3'd2,
        REQ_LOCATE = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    // Result word handed from the sequencer to the output stage
    typedef struct packed {
        logic                done;
        t_status             status;
        logic [WORD_W-1:0]   read_value;
        logic [POS_W-1:0]    found_pos;
    } t_result;

endpackage

### sv/olt_seq.sv
`timescale 1ns / 1ps
// List sequencer: element memory, entry count and the shared step/compare unit
// that walks the memory one entry per cycle. Depends on olt_pkg.
module olt_seq #(
    parameter int  CAPACITY = olt_pkg::CAPACITY_DEF,
    localparam int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  olt_pkg::t_req              i_req_type,
    input  logic [olt_pkg::POS_W-1:0]  i_position,
    input  logic [olt_pkg::WORD_W-1:0] i_value,
    output logic                       o_busy,
    output olt_pkg::t_result           o_result,
    output logic [CW-1:0]              o_count
);
    import olt_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RUN,
        S_DRAIN,
        S_INS
    } t_state;

    t_state            r_state;
    t_req              r_req;
    logic [POS_W-1:0]  r_pos;
    logic [WORD_W-1:0] r_value;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     r_lim;
    logic              r_down;
    logic              r_rd_v;
    logic [AW-1:0]     r_rd_src;
    logic              r_first;
    logic              r_hit;
    logic [CW-1:0]     r_found;
    logic [WORD_W-1:0] r_readv;
    t_status           r_status;
    logic              r_done;

    logic [WORD_W-1:0] mem [CAPACITY];
    logic [WORD_W-1:0] r_rdata;

    logic [PW-1:0]     w_posw;
    logic [PW-1:0]     w_cntw;
    logic              w_pos_ok;
    logic              w_ins_ok;
    logic              w_full;
    logic [AW-1:0]     w_p0;
    logic [CW-1:0]     w_step;
    logic              w_at_lim;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;

    // Position checks against the current count
    assign w_posw   = PW'(r_pos);
    assign w_cntw   = PW'(r_count);
    assign w_pos_ok = (w_posw != '0) && (w_posw <= w_cntw);
    assign w_ins_ok = (w_posw != '0) && (w_posw <= w_cntw + PW'(1));
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_p0     = AW'(w_posw - PW'(1));

    // Shared step unit: advance the walk pointer and test for the end
    assign w_step   = r_down ? (r_ptr - CW'(1)) : (r_ptr + CW'(1));
    assign w_at_lim = (r_ptr == r_lim);

    // Memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_src;
        w_wdata = r_rdata;
        if (r_state == S_INS) begin
            w_we    = 1'b1;
            w_waddr = w_p0;
            w_wdata = r_value;
        end else if (r_rd_v && (r_req == REQ_INSERT)) begin
            w_we    = 1'b1;
            w_waddr = r_rd_src + AW'(1);
        end else if (r_rd_v && (r_req == REQ_DELETE) && !r_first) begin
            w_we    = 1'b1;
            w_waddr = r_rd_src - AW'(1);
        end
    end

    always_comb begin
        w_re    = 1'b0;
        w_raddr = r_ptr[AW-1:0];
        if (r_state == S_RUN) begin
            w_re = 1'b1;
        end else if ((r_state == S_CHECK) && (r_req == REQ_GET) && w_pos_ok) begin
            w_re    = 1'b1;
            w_raddr = w_p0;
        end
    end

    // Element memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= mem[w_raddr];
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rd_v  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;

            // Consume the word read in the previous cycle
            if (r_rd_v) begin
                r_first <= 1'b0;
                if (r_first) begin
                    r_readv <= r_rdata;
                end
                if ((r_req == REQ_LOCATE) && !r_hit && (r_rdata == r_value)) begin
                    r_hit   <= 1'b1;
                    r_found <= CW'(r_rd_src) + CW'(1);
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req    <= i_req_type;
                        r_pos    <= i_position;
                        r_value  <= i_value;
                        r_status <= ST_OK;
                        r_readv  <= '0;
                        r_found  <= '0;
                        r_hit    <= 1'b0;
                        r_first  <= 1'b0;
                        r_state  <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    unique case (r_req)
                        REQ_GET: begin
                            if (w_pos_ok) begin
                                r_rd_v   <= 1'b1;
                                r_rd_src <= w_p0;
                                r_first  <= 1'b1;
                                r_state  <= S_DRAIN;
                            end else begin
                                r_status <= ST_BAD_POS;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                        REQ_INSERT: begin
                            if (!w_ins_ok) begin
                                r_status <= ST_BAD_POS;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else if (r_count > CW'(w_p0)) begin
                                r_ptr   <= r_count - CW'(1);
                                r_lim   <= CW'(w_p0);
                                r_down  <= 1'b1;
                                r_state <= S_RUN;
                            end else begin
                                r_state <= S_INS;
                            end
                        end
                        REQ_DELETE: begin
                            if (w_pos_ok) begin
                                r_ptr   <= CW'(w_p0);
                                r_lim   <= r_count - CW'(1);
                                r_down  <= 1'b0;
                                r_first <= 1'b1;
                                r_state <= S_RUN;
                            end else begin
                                r_status <= ST_BAD_POS;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end
                        end
                        REQ_LOCATE: begin
                            if (r_count != '0) begin
                                r_ptr   <= '0;
                                r_lim   <= r_count - CW'(1);
                                r_down  <= 1'b0;
                                r_state <= S_RUN;
                            end else begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        REQ_CLEAR: begin
                            r_count <= '0;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_RUN: begin
                    // Issue one read per cycle until the limit entry
                    r_rd_v   <= 1'b1;
                    r_rd_src <= r_ptr[AW-1:0];
                    if (w_at_lim) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_ptr <= w_step;
                    end
                end
                S_DRAIN: begin
                    r_rd_v <= 1'b0;
                    if (r_req == REQ_INSERT) begin
                        r_state <= S_INS;
                    end else begin
                        if (r_req == REQ_DELETE) begin
                            r_count <= r_count - CW'(1);
                        end
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_INS: begin
                    r_count <= r_count + CW'(1);
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy              = (r_state != S_IDLE);
    assign o_count             = r_count;
    assign o_result.done       = r_done;
    assign o_result.status     = r_status;
    assign o_result.read_value = r_readv;
    assign o_result.found_pos  = POS_W'(r_found);

endmodule

### sv/ordered_list_table_unit.sv
`timescale 1ns / 1ps
// Ordered list table, top level: request capture, sequencer and result registers.
// Depends on olt_pkg and olt_seq.
//
//  channel  | handshake                  | words
//  ---------+----------------------------+------------------------------------------
//  request  | start high while busy low  | i_req_type, i_position, i_value
//  result   | o_done, one cycle, no hold | o_status, o_read_value, o_found_position,
//           |                            | o_item_count, o_is_empty
//
// A get reads its entry directly; a rejected, clear, ignored or empty-list request
// finishes without a memory walk. Delete and locate walk the entries one per cycle
// on the single memory port pair; insert walks the entries it moves and then
// writes the new entry in its own state.
// busy drops in the cycle before the result is strobed.
// Reset (synchronous, active low) empties the list; no clearing pass is needed.
// The receiver cannot stall: each result is shown for exactly one cycle.
module ordered_list_table_unit #(
    parameter int CAPACITY = olt_pkg::CAPACITY_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [2:0]                 i_req_type,
    input  logic [olt_pkg::POS_W-1:0]  i_position,
    input  logic signed [olt_pkg::WORD_W-1:0] i_value,
    output logic                       o_done,
    output logic [1:0]                 o_status,
    output logic signed [olt_pkg::WORD_W-1:0] o_read_value,
    output logic [olt_pkg::POS_W-1:0]  o_found_position,
    output logic [olt_pkg::POS_W-1:0]  o_item_count,
    output logic                       o_is_empty
);
    import olt_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_result           w_result;
    logic [CW-1:0]     w_count;
    logic              w_busy;

    logic              r_done;
    logic [1:0]        r_status;
    logic [WORD_W-1:0] r_read_value;
    logic [POS_W-1:0]  r_found;
    logic [POS_W-1:0]  r_item_count;
    logic              r_is_empty;

    olt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (t_req'(i_req_type)),
        .i_position (i_position),
        .i_value    (i_value),
        .o_busy     (w_busy),
        .o_result   (w_result),
        .o_count    (w_count)
    );

    // Hold the result word for its single strobe cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_result.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result.done) begin
            r_status     <= w_result.status;
            r_read_value <= w_result.read_value;
            r_found      <= w_result.found_pos;
            r_item_count <= POS_W'(w_count);
            r_is_empty   <= (w_count == '0);
        end
    end

    assign busy             = w_busy;
    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_read_value     = r_read_value;
    assign o_found_position = r_found;
    assign o_item_count     = r_item_count;
    assign o_is_empty       = r_is_empty;

    // An accepted word keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // A result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_busy, 2))
        else $error("result strobe without pending request");

    // The count moves by one step or drops to zero
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_count != $past(w_count)) |->
        ((w_count == $past(w_count) + CW'(1)) || (w_count == $past(w_count) - CW'(1))
         || (w_count == '0)))
        else $error("entry count jumped");

    // The count never exceeds the capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

endmodule

### bench/ordered_list_table_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for ordered_list_table_unit: a directed table, random requests, a fill to capacity and probes.
// Holds its own list image to predict the result words not given by the directed table; depends on olt_pkg and the RTL.
module ordered_list_table_unit_test;
    import olt_pkg::*;

    // Request codes the block ignores
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_status            status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         item_count;
        logic               is_empty;
    } list_result_t;

    typedef struct {
        logic [2:0]         req;
        logic [7:0]         pos;
        logic signed [31:0] val;
        bit                 typed;
        list_result_t       want;
    } step_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [2:0]          i_req_type;
    logic [7:0]          i_position;
    logic signed [31:0]  i_value;
    logic                o_done;
    logic [1:0]          o_status;
    logic signed [31:0]  o_read_value;
    logic [7:0]          o_found_position;
    logic [7:0]          o_item_count;
    logic                o_is_empty;

    // Predictor state and the results still owed by the block
    logic signed [31:0]  list_image[$];
    list_result_t        pending_results[$];
    list_result_t        unused_result;
    bit                  pend_typed;
    list_result_t        pend_want;
    int                  mismatch_count = 0;

    ordered_list_table_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_req_type       (i_req_type),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_read_value     (o_read_value),
        .o_found_position (o_found_position),
        .o_item_count     (o_item_count),
        .o_is_empty       (o_is_empty)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one request to the list image and return the result word it should give
    function automatic list_result_t apply_request(logic [2:0] req, logic [7:0] pos,
                                                   logic signed [31:0] val);
        list_result_t r;
        int n;
        r.status         = ST_OK;
        r.read_value     = '0;
        r.found_position = '0;
        n = list_image.size();
        case (req)
            REQ_GET: begin
                if (pos >= 1 && pos <= n) r.read_value = list_image[pos - 1];
                else r.status = ST_BAD_POS;
            end
            REQ_INSERT: begin
                if (pos < 1 || pos > n + 1) r.status = ST_BAD_POS;
                else if (n >= CAPACITY_DEF) r.status = ST_FULL;
                else list_image.insert(pos - 1, val);
            end
            REQ_DELETE: begin
                if (pos >= 1 && pos <= n) begin
                    r.read_value = list_image[pos - 1];
                    list_image.delete(pos - 1);
                end else begin
                    r.status = ST_BAD_POS;
                end
            end
            REQ_LOCATE: begin
                // first equal entry wins
                for (int k = 0; k < n; k++)
                    if (list_image[k] == val && r.found_position == 0)
                        r.found_position = 8'(k + 1);
            end
            REQ_CLEAR: list_image.delete();
            default: ;
        endcase
        r.item_count = 8'(list_image.size());
        r.is_empty   = (list_image.size() == 0);
        return r;
    endfunction

    function automatic step_t step_row(logic [2:0] req, logic [7:0] pos, logic signed [31:0] val,
                                       bit typed, t_status st, logic signed [31:0] rd,
                                       logic [7:0] found, logic [7:0] cnt);
        step_t s;
        s.req = req;
        s.pos = pos;
        s.val = val;
        s.typed = typed;
        s.want.status = st;
        s.want.read_value = rd;
        s.want.found_position = found;
        s.want.item_count = cnt;
        s.want.is_empty = (cnt == 0);
        return s;
    endfunction

    // Mix extremes, stored entries (to hit duplicates and locate) and raw random words
    function automatic logic signed [31:0] pick_value(bit from_list);
        int n;
        n = list_image.size();
        if (n > 0 && (from_list ? ($urandom_range(0, 2) != 0) : ($urandom_range(0, 5) == 0)))
            return list_image[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 7))
            0: return WORD_MIN;
            1: return WORD_MAX;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed requests at valid positions, with some noise positions
    task automatic choose_mixed(output logic [2:0] req, output logic [7:0] pos,
                                output logic signed [31:0] val);
        int n;
        int roll;
        n = list_image.size();
        roll = $urandom_range(0, 99);
        if (roll < 24) req = REQ_GET;
        else if (roll < 56) req = REQ_INSERT;
        else if (roll < 78) req = REQ_DELETE;
        else if (roll < 93) req = REQ_LOCATE;
        else if (roll < 96) req = REQ_CLEAR;
        else req = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        if ($urandom_range(0, 4) == 0) pos = 8'($urandom_range(0, 255));
        else if (req == REQ_INSERT) pos = 8'($urandom_range(1, n + 1));
        else pos = 8'($urandom_range(1, (n > 0) ? n : 1));
        val = pick_value(req == REQ_LOCATE);
    endtask

    // Called at a falling edge: optionally idle, then present one word and hold it until taken
    task automatic send_word(input logic [2:0] req, input logic [7:0] pos,
                             input logic signed [31:0] val, input bit typed,
                             input list_result_t want, input bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            // half of the bursts start once the block has gone idle
            if ($urandom_range(0, 1) == 1)
                while (busy) @(negedge i_clk);
            repeat (gap) @(negedge i_clk);
        end
        i_req_type <= req;
        i_position <= pos;
        i_value    <= val;
        start      <= 1'b1;
        pend_typed = typed;
        pend_want  = want;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic probe(input logic [2:0] req, input logic [7:0] pos,
                         input logic signed [31:0] val);
        @(negedge i_clk);
        send_word(req, pos, val, 1'b0, unused_result, 1'b1);
    endtask

    task automatic compare_field(input string what, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatch_count++;
        end
    endtask

    // Check each strobed result, then record the word taken at this edge
    always @(posedge i_clk) begin : result_check
        list_result_t want_r;
        list_result_t pred_r;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual status %0d",
                             $time, o_status);
                    mismatch_count++;
                end else begin
                    want_r = pending_results.pop_front();
                    compare_field("status", want_r.status, o_status);
                    compare_field("read_value", want_r.read_value, o_read_value);
                    compare_field("found_position", want_r.found_position, o_found_position);
                    compare_field("item_count", want_r.item_count, o_item_count);
                    compare_field("is_empty", want_r.is_empty, o_is_empty);
                end
            end
            if (start && !busy) begin
                pred_r = apply_request(i_req_type, i_position, i_value);
                pending_results.push_back(pend_typed ? pend_want : pred_r);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("ordered_list_table_unit regression: fail");
        $finish;
    end

    initial begin : stimulus
        step_t              steps[$];
        logic [2:0]         req;
        logic [7:0]         pos;
        logic signed [31:0] val;

        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_req_type = '0;
        i_position = '0;
        i_value    = '0;
        pend_typed = 1'b0;
        unused_result = apply_request(REQ_SPARE_FIRST, 8'd0, 32'sd0);
        pend_want  = unused_result;

        // Directed table: empty-list errors, extremes, ordering, first-equal locate,
        // ignored request codes, delete at both ends, clear
        steps.push_back(step_row(REQ_GET,    8'd1,   32'sd0,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_DELETE, 8'd0,   32'sd0,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_LOCATE, 8'd0,   32'sd0,   1, ST_OK,      32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_INSERT, 8'd0,   32'sd5,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_INSERT, 8'd2,   32'sd5,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_INSERT, 8'd1,   WORD_MAX, 1, ST_OK,      32'sd0, 8'd0, 8'd1));
        steps.push_back(step_row(REQ_INSERT, 8'd1,   WORD_MIN, 1, ST_OK,      32'sd0, 8'd0, 8'd2));
        steps.push_back(step_row(REQ_INSERT, 8'd3,   -32'sd1,  1, ST_OK,      32'sd0, 8'd0, 8'd3));
        steps.push_back(step_row(REQ_INSERT, 8'd2,   32'sd0,   0, ST_OK,      32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_GET,    8'd1,   32'sd0,   1, ST_OK,    WORD_MIN, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_GET,    8'd4,   32'sd0,   1, ST_OK,     -32'sd1, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_GET,    8'd5,   32'sd0,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_GET,    8'd255, 32'sd0,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_LOCATE, 8'd0,   WORD_MAX, 1, ST_OK,      32'sd0, 8'd3, 8'd4));
        steps.push_back(step_row(REQ_LOCATE, 8'd0,  32'sd12345, 1, ST_OK,     32'sd0, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_INSERT, 8'd5, 32'sh5A5A_5A5A, 0, ST_OK,  32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_INSERT, 8'd2,   -32'sd1,  0, ST_OK,      32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_LOCATE, 8'd0,   -32'sd1,  1, ST_OK,      32'sd0, 8'd2, 8'd6));
        steps.push_back(step_row(REQ_SPARE_FIRST, 8'd1, 32'sd7, 1, ST_OK,     32'sd0, 8'd0, 8'd6));
        steps.push_back(step_row(REQ_SPARE_LAST, 8'd255, -32'sd1, 1, ST_OK,   32'sd0, 8'd0, 8'd6));
        steps.push_back(step_row(REQ_DELETE, 8'd6, 32'sd0, 1, ST_OK, 32'sh5A5A_5A5A, 8'd0, 8'd5));
        steps.push_back(step_row(REQ_DELETE, 8'd1,   32'sd0,   1, ST_OK,    WORD_MIN, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_DELETE, 8'd5,   32'sd0,   1, ST_BAD_POS, 32'sd0, 8'd0, 8'd4));
        steps.push_back(step_row(REQ_CLEAR,  8'd0,   32'sd0,   1, ST_OK,      32'sd0, 8'd0, 8'd0));
        steps.push_back(step_row(REQ_INSERT, 8'd1, 32'sh0000_0080, 1, ST_OK,  32'sd0, 8'd0, 8'd1));

        // Hold reset, release on a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (steps[i]) begin
            @(negedge i_clk);
            send_word(steps[i].req, steps[i].pos, steps[i].val, steps[i].typed,
                      steps[i].want, 1'b1);
        end

        // Random mix with sender idling
        repeat (120) begin
            @(negedge i_clk);
            choose_mixed(req, pos, val);
            send_word(req, pos, val, 1'b0, unused_result, 1'b1);
        end

        // Fill the list to capacity at random positions
        while (list_image.size() < CAPACITY_DEF) begin
            @(negedge i_clk);
            pos = 8'($urandom_range(1, list_image.size() + 1));
            send_word(REQ_INSERT, pos, pick_value(1'b0), 1'b0, unused_result, 1'b1);
        end

        // Probe the full list: inserts are refused, bounds move with the count
        probe(REQ_INSERT, 8'd1, 32'sd7);
        probe(REQ_INSERT, 8'(CAPACITY_DEF + 1), 32'sd7);
        probe(REQ_INSERT, 8'(CAPACITY_DEF + 2), 32'sd7);
        probe(REQ_GET, 8'(CAPACITY_DEF), 32'sd0);
        probe(REQ_GET, 8'(CAPACITY_DEF + 1), 32'sd0);
        probe(REQ_LOCATE, 8'd0, list_image[CAPACITY_DEF - 1]);
        probe(REQ_DELETE, 8'(CAPACITY_DEF), 32'sd0);
        probe(REQ_DELETE, 8'd1, 32'sd0);

        // Drain: hold off until every owed result has come
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);

        repeat (130) begin
            @(negedge i_clk);
            choose_mixed(req, pos, val);
            send_word(req, pos, val, 1'b0, unused_result, 1'b1);
        end

        // Back-to-back tail, no idling
        repeat (50) begin
            @(negedge i_clk);
            choose_mixed(req, pos, val);
            send_word(req, pos, val, 1'b0, unused_result, 1'b0);
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY_DEF + 8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("ordered_list_table_unit regression: pass");
        end else begin
            $display("ordered_list_table_unit regression: fail");
        end
        $finish;
    end

endmodule
